### src/dski_pkg.sv
// ----------------------------------------------------------------------------
// dski_pkg
// Shared widths, codes and types of the dual-switch key interlock.
// ----------------------------------------------------------------------------
package dski_pkg;

  localparam int unsigned ScanW    = 60;
  localparam int unsigned ScanIdxW = 6;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned MsW      = 16;
  localparam int unsigned ColW     = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned RowsPerSideDef = 5;
  localparam int unsigned ColsDef        = 6;

  localparam logic [MsW-1:0]  GraceMsRst    = 16'd50;
  localparam logic [MsW-1:0]  ReplayMsRst   = 16'd10;
  localparam logic [ColW-1:0] DownColRst    = 3'd2;
  localparam logic [ColW-1:0] DblDownColRst = 3'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRACE_MS    = 2'd0,
    CFG_REPLAY_MS   = 2'd1,
    CFG_DOWN_COL    = 2'd2,
    CFG_DBL_DOWN_COL = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_PENDING = 5'b00010,
    MODE_DOWN    = 5'b00100,
    MODE_DD      = 5'b01000,
    MODE_REPLAY  = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [MsW-1:0]  grace_ms;
    logic [MsW-1:0]  replay_ms;
    logic [ColW-1:0] down_col;
    logic [ColW-1:0] dbl_down_col;
  } cfg_t;

  // per-cluster verdict for one scan
  typedef struct packed {
    logic [ScanW-1:0] dm_mask;  // Down position, zero if column off the matrix
    logic             dm_val;   // value Down takes in the output
    logic             hold;     // commit forced by a new press: hold it back
    logic             chg;      // cluster mode moved
  } clu_res_t;

  // one-hot mask of a key in a row, empty when the column is off the matrix
  function automatic logic [ScanW-1:0] key_mask(input logic [ScanIdxW-1:0] base,
                                                input logic [ColW-1:0]     col,
                                                input logic [ColW-1:0]     cols);
    logic [ScanW-1:0] m;
    m = '0;
    if (col < cols) begin
      m = ScanW'(1) << (base + ScanIdxW'(col));
    end
    return m;
  endfunction

endpackage

### src/dski_if.sv
// ----------------------------------------------------------------------------
// dski_if
// Valid/ready channels of the key interlock: scan in, result out, config.
// ----------------------------------------------------------------------------
interface dski_scan_if import dski_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ScanW-1:0] scan_bits;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, output scan_bits, output now_ms, input ready);
  modport sink   (input valid, input scan_bits, input now_ms, output ready);
endinterface

interface dski_res_if import dski_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ScanW-1:0] out_bits;
  logic             changed;

  modport source (output valid, output out_bits, output changed, input ready);
  modport sink   (input valid, input out_bits, input changed, output ready);
endinterface

interface dski_cfg_if import dski_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/dual_switch_key_interlock_unit.sv
// ----------------------------------------------------------------------------
// dual_switch_key_interlock_unit
// Down/DoubleDown interlock for the two thumb clusters of a split matrix.
// ----------------------------------------------------------------------------
// Channels: scan_i takes one debounced scan word (scan_bits, now_ms);
// res_o gives one word per scan (out_bits, changed); cfg_i writes the
// grace time, replay time and the two thumb columns by register index.
// A scan is taken into an input register, judged combinationally by the two
// cluster state machines and written to the result register, which offers
// it on res_o. While res_o is not stalled, one scan can be taken every
// cycle; the cluster state, previous scan and held-back presses are
// updated as each scan moves into the result register.
// When the receiver stalls, the result register holds its word and the
// input register still takes one more scan; after that scan_i.ready drops
// until res_o is drained.
// Reset clears both clusters to idle, the previous scan and held presses
// to zero, and loads the default configuration. Config is taken at once
// (cfg_i.ready is always high) and should be written only while idle.
// ----------------------------------------------------------------------------
module dual_switch_key_interlock_unit import dski_pkg::*; #(
  parameter int unsigned ROWS_PER_SIDE = RowsPerSideDef,
  parameter int unsigned COLS          = ColsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dski_scan_if.sink  scan_i,
  dski_res_if.source res_o,
  dski_cfg_if.sink   cfg_i
);

  localparam int unsigned TotalBits = 2 * ROWS_PER_SIDE * COLS;
  localparam logic [ScanW-1:0] VMask = (ScanW'(1) << TotalBits) - ScanW'(1);
  localparam logic [ScanIdxW-1:0] Row1Base = ScanIdxW'(ROWS_PER_SIDE * COLS);
  localparam logic [ColW-1:0]     NCols    = ColW'(COLS);

  cfg_t             cfg;
  clu_res_t         clu0, clu1;

  logic             in_vld_q;
  logic [ScanW-1:0] in_scan_q;
  logic [TimeW-1:0] in_now_q;
  logic             res_vld_q;
  logic [ScanW-1:0] res_bits_q, res_bits_d;
  logic             res_chg_q, res_chg_d;
  logic [ScanW-1:0] prev_q, held_q, held_d;

  logic             adv, in_acc;
  logic [ScanW-1:0] phys, excl, fresh, clr, outm;

  assign adv           = in_vld_q & (~res_vld_q | res_o.ready);
  assign scan_i.ready  = ~in_vld_q | adv;
  assign in_acc        = scan_i.valid & scan_i.ready;

  dski_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign phys  = in_scan_q & VMask;
  assign excl  = key_mask('0, cfg.down_col, NCols)
               | key_mask('0, cfg.dbl_down_col, NCols)
               | key_mask(Row1Base, cfg.down_col, NCols)
               | key_mask(Row1Base, cfg.dbl_down_col, NCols);
  assign fresh = phys & ~prev_q & ~excl;

  dski_cluster #(.ROW(0), .COLS(COLS)) u_clu0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .phys_i  (phys),
    .now_i   (in_now_q),
    .fresh_i (|fresh),
    .cfg_i   (cfg),
    .res_o   (clu0)
  );

  dski_cluster #(.ROW(ROWS_PER_SIDE), .COLS(COLS)) u_clu1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .phys_i  (phys),
    .now_i   (in_now_q),
    .fresh_i (|fresh),
    .cfg_i   (cfg),
    .res_o   (clu1)
  );

  // thumb rows differ, and fresh never covers a Down bit, so the edits commute
  always_comb begin
    clr    = (clu0.hold | clu1.hold) ? fresh : '0;
    outm   = phys;
    outm   = (outm & ~clu0.dm_mask) | (clu0.dm_mask & {ScanW{clu0.dm_val}});
    outm   = (outm & ~clu1.dm_mask) | (clu1.dm_mask & {ScanW{clu1.dm_val}});
    held_d = clr;
    res_bits_d = ((outm & ~clr) | held_q) & VMask;
    res_chg_d  = clu0.chg | clu1.chg | (prev_q != phys);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      prev_q    <= '0;
      held_q    <= '0;
    end else begin
      if (scan_i.ready) begin
        in_vld_q <= scan_i.valid;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
        prev_q    <= phys;
        held_q    <= held_d;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_scan_q <= scan_i.scan_bits;
      in_now_q  <= scan_i.now_ms;
    end
    if (adv) begin
      res_bits_q <= res_bits_d;
      res_chg_q  <= res_chg_d;
    end
  end

  assign res_o.valid    = res_vld_q;
  assign res_o.out_bits = res_bits_q;
  assign res_o.changed  = res_chg_q;

  a_held_off_thumbs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q & ~VMask) == '0)
    else $error("held press outside the matrix");

  a_out_in_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> ((res_bits_q & ~VMask) == '0))
    else $error("result has bits beyond the matrix");

  a_held_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && held_q != '0) |=> ((res_bits_q & $past(held_q)) == $past(held_q)))
    else $error("held press not replayed in the next result");

  a_prev_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (prev_q == $past(phys)))
    else $error("previous scan not updated");

endmodule

### src/dski_cfg.sv
// ----------------------------------------------------------------------------
// dski_cfg
// Configuration register file: grace and replay times, Down columns.
// ----------------------------------------------------------------------------
module dski_cfg import dski_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dski_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_GRACE_MS:     cfg_d.grace_ms     = cfg_i.data;
        CFG_REPLAY_MS:    cfg_d.replay_ms    = cfg_i.data;
        CFG_DOWN_COL:     cfg_d.down_col     = cfg_i.data[ColW-1:0];
        CFG_DBL_DOWN_COL: cfg_d.dbl_down_col = cfg_i.data[ColW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grace_ms     <= GraceMsRst;
      cfg_q.replay_ms    <= ReplayMsRst;
      cfg_q.down_col     <= DownColRst;
      cfg_q.dbl_down_col <= DblDownColRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/dski_cluster.sv
// ----------------------------------------------------------------------------
// dski_cluster
// Thumb-cluster state machine: decides what Down shows for one scan.
// ----------------------------------------------------------------------------
module dski_cluster import dski_pkg::*; #(
  parameter int unsigned ROW          = 0,
  parameter int unsigned COLS         = ColsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,      // scan moves to the result register
  input  logic [ScanW-1:0] phys_i,
  input  logic [TimeW-1:0] now_i,
  input  logic             fresh_i,    // some key other than Down or DoubleDown newly pressed
  input  cfg_t             cfg_i,
  output clu_res_t         res_o
);

  localparam logic [ScanIdxW-1:0] RowBase = ScanIdxW'(ROW * COLS);
  localparam logic [ColW-1:0]     NCols   = ColW'(COLS);

  mode_e            mode_q, mode_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [ScanW-1:0] dm, ddm;
  logic [TimeW-1:0] elapsed;
  logic             raw, dd;
  logic             dm_val, hold;

  assign dm      = key_mask(RowBase, cfg_i.down_col, NCols);
  assign ddm     = key_mask(RowBase, cfg_i.dbl_down_col, NCols);
  assign raw     = |(phys_i & dm);
  assign dd      = |(phys_i & ddm);
  assign elapsed = now_i - start_q;

  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    dm_val  = 1'b0;
    hold    = 1'b0;
    case (mode_q)
      MODE_PENDING: begin
        if (dd) begin
          mode_d = MODE_DD;
        end else if (!raw) begin
          // quick release: replay as a tap
          mode_d  = MODE_REPLAY;
          start_d = now_i;
          dm_val  = 1'b1;
        end else if (fresh_i) begin
          mode_d  = MODE_DOWN;
          start_d = now_i;
          dm_val  = 1'b1;
          hold    = 1'b1;
        end else if (elapsed >= TimeW'(cfg_i.grace_ms)) begin
          mode_d  = MODE_DOWN;
          start_d = now_i;
          dm_val  = 1'b1;
        end
      end
      MODE_DOWN: begin
        dm_val = raw & ~dd;
        if (dd) begin
          mode_d = MODE_DD;
        end else if (!raw) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_DD: begin
        if (!raw && !dd) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_REPLAY: begin
        if (dd) begin
          mode_d = MODE_DD;
        end else if (elapsed >= TimeW'(cfg_i.replay_ms)) begin
          mode_d = MODE_IDLE;
        end else begin
          dm_val = 1'b1;
        end
      end
      default: begin
        // idle, and any stray code treated as idle
        mode_d = MODE_IDLE;
        if (dd) begin
          mode_d = MODE_DD;
        end else if (raw) begin
          mode_d  = MODE_PENDING;
          start_d = now_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
    end
  end

  assign res_o.dm_mask = dm;
  assign res_o.dm_val  = dm_val;
  assign res_o.hold    = hold;
  assign res_o.chg     = (mode_d != mode_q);

  a_hold_commits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && hold) |=> (mode_q == MODE_DOWN && start_q == $past(now_i)))
    else $error("forced commit did not land in down committed");

  a_mode_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> ($stable(mode_q) && $stable(start_q)))
    else $error("cluster state moved without a scan");

  a_dd_hides_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dd |-> !dm_val)
    else $error("Down shown while DoubleDown pressed");

endmodule
